[hdl/dwr_pkg.sv]
package dwr_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);
   localparam logic [COUNT_W:0]   CAP_SUM   = (COUNT_W + 1)'(CAPACITY);
   localparam logic [ADDR_W-1:0]  LAST_SLOT = ADDR_W'(CAPACITY - 1);

   typedef enum logic [2:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_BACK  = 3'd1,
      REQ_REVERSE    = 3'd2,
      REQ_POP_FRONT  = 3'd3,
      REQ_POP_BACK   = 3'd4
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic              we;
      logic              re;
      logic [ADDR_W-1:0] addr;
   } mem_cmd_type;

   typedef struct packed {
      status_type         status;
      logic               is_pop;
      logic [COUNT_W-1:0] occupancy;
   } result_type;

   // Slot k places after s, wrapping round the circular store.
   function automatic logic [ADDR_W-1:0] slot_offset(input logic [ADDR_W-1:0]  s,
                                                     input logic [COUNT_W-1:0] k);
      logic [COUNT_W:0] sum;
      sum = (COUNT_W + 1)'(s) + (COUNT_W + 1)'(k);
      if (sum >= CAP_SUM) begin
         sum = sum - CAP_SUM;
      end
      return sum[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] slot_before(input logic [ADDR_W-1:0] s);
      return (s == '0) ? LAST_SLOT : s - ADDR_W'(1);
   endfunction

endpackage

[hdl/dwr_ram.sv]
module dwr_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

[hdl/dwr_ctrl.sv]
module dwr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [2:0]            req_type,
   output dwr_pkg::mem_cmd_type  mem_cmd,
   output dwr_pkg::result_type   result
);

   logic [dwr_pkg::ADDR_W-1:0]  front_ff, front_in;
   logic [dwr_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        rev_ff, rev_in;
   logic                        push_low;
   logic                        pop_low;

   // The physical low end is the logical front unless the order is reversed.
   assign push_low = (req_type == dwr_pkg::REQ_PUSH_FRONT) != rev_ff;
   assign pop_low  = (req_type == dwr_pkg::REQ_POP_FRONT) != rev_ff;

   always_comb begin
      front_in       = front_ff;
      count_in       = count_ff;
      rev_in         = rev_ff;
      mem_cmd.we     = 1'b0;
      mem_cmd.re     = 1'b0;
      mem_cmd.addr   = front_ff;
      result.status  = dwr_pkg::ST_DONE;
      result.is_pop  = 1'b0;
      unique case (req_type)
         dwr_pkg::REQ_PUSH_FRONT, dwr_pkg::REQ_PUSH_BACK: begin
            if (count_ff == dwr_pkg::CAP_COUNT) begin
               result.status = dwr_pkg::ST_FULL;
            end else begin
               if (push_low) begin
                  front_in     = dwr_pkg::slot_before(front_ff);
                  mem_cmd.addr = front_in;
               end else begin
                  mem_cmd.addr = dwr_pkg::slot_offset(front_ff, count_ff);
               end
               mem_cmd.we = accept;
               count_in   = count_ff + dwr_pkg::COUNT_W'(1);
            end
         end
         dwr_pkg::REQ_REVERSE: begin
            rev_in = !rev_ff;
         end
         dwr_pkg::REQ_POP_FRONT, dwr_pkg::REQ_POP_BACK: begin
            if (count_ff == '0) begin
               result.status = dwr_pkg::ST_EMPTY;
            end else begin
               if (pop_low) begin
                  mem_cmd.addr = front_ff;
                  front_in     = dwr_pkg::slot_offset(front_ff, dwr_pkg::COUNT_W'(1));
               end else begin
                  mem_cmd.addr = dwr_pkg::slot_offset(front_ff,
                                                      count_ff - dwr_pkg::COUNT_W'(1));
               end
               mem_cmd.re    = accept;
               result.is_pop = 1'b1;
               count_in      = count_ff - dwr_pkg::COUNT_W'(1);
            end
         end
         default: begin
         end
      endcase
      result.occupancy = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else if (accept) begin
         front_ff <= front_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

endmodule

[hdl/deque_with_reverse.sv]
// Double-ended queue with whole-order reversal, held in one single-port memory.
// A result word appears in the cycle after its request word is accepted.
// Throughput: one word per cycle unless stalled; each uses the memory port at most once.
// Reset clears the front slot, count and reversed flag; memory contents are left as they are
// and need no clearing pass, so requests are taken from the first cycle after reset.
module deque_with_reverse (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_type,
   input  logic signed [dwr_pkg::DATA_W-1:0]   req_push_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic signed [dwr_pkg::DATA_W-1:0]   rsp_popped_value,
   output logic                                rsp_is_pop_result,
   output logic [dwr_pkg::COUNT_W-1:0]         rsp_occupancy
);

   logic                        accept;
   dwr_pkg::mem_cmd_type        mem_cmd;
   dwr_pkg::result_type         result;
   logic [dwr_pkg::DATA_W-1:0]  rdata;
   logic                        valid_ff;
   dwr_pkg::result_type         result_ff;

   assign req_stall = valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   dwr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_type (req_type),
      .mem_cmd  (mem_cmd),
      .result   (result)
   );

   // The read data register only loads on a pop, so it holds while a result is stalled.
   dwr_ram #(
      .WIDTH (dwr_pkg::DATA_W),
      .DEPTH (dwr_pkg::CAPACITY)
   ) u_ram (
      .clock (clock),
      .en    (mem_cmd.we || mem_cmd.re),
      .we    (mem_cmd.we),
      .addr  (mem_cmd.addr),
      .wdata (req_push_value),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = result_ff.status;
   assign rsp_is_pop_result = result_ff.is_pop;
   assign rsp_occupancy     = result_ff.occupancy;
   assign rsp_popped_value  = result_ff.is_pop ? signed'(rdata) : '0;

endmodule

[bench/tb.sv]
module tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SHOWN_MISMATCHES = 10;

   // Request codes the block must ignore.
   localparam logic [2:0] REQ_UNUSED_LO  = 3'd5;
   localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
   localparam logic [2:0] REQ_UNUSED_HI  = 3'd7;

   typedef struct {
      dwr_pkg::status_type         status;
      logic [dwr_pkg::DATA_W-1:0]  popped;
      logic                        is_pop;
      logic [dwr_pkg::COUNT_W-1:0] occupancy;
   } deque_outcome_type;

   logic                                clock;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [2:0]                          req_type = dwr_pkg::REQ_PUSH_FRONT;
   logic signed [dwr_pkg::DATA_W-1:0]   req_push_value = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [1:0]                          rsp_status;
   logic signed [dwr_pkg::DATA_W-1:0]   rsp_popped_value;
   logic                                rsp_is_pop_result;
   logic [dwr_pkg::COUNT_W-1:0]         rsp_occupancy;

   deque_outcome_type expected_outcomes[$];

   // Shadow copy of the deque, kept in step with every accepted request word.
   logic [dwr_pkg::DATA_W-1:0] shadow_store [dwr_pkg::CAPACITY];
   int   shadow_front = 0;
   int   shadow_count = 0;
   logic shadow_reversed = 1'b0;

   int send_idle_pct = 12;
   int recv_idle_pct = 45;
   int mismatch_count = 0;
   int cycle_count = 0;

   deque_with_reverse DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_push_value    (req_push_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_is_pop_result (rsp_is_pop_result),
      .rsp_occupancy     (rsp_occupancy)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   function automatic deque_outcome_type apply_request(
         input logic [2:0] kind, input logic [dwr_pkg::DATA_W-1:0] value);
      deque_outcome_type res;
      logic low_end;
      res.status = dwr_pkg::ST_DONE;
      res.popped = '0;
      res.is_pop = 1'b0;
      case (kind)
         dwr_pkg::REQ_PUSH_FRONT, dwr_pkg::REQ_PUSH_BACK: begin
            // With the order reversed, the logical front sits at the physical high end.
            low_end = (kind == dwr_pkg::REQ_PUSH_FRONT) != shadow_reversed;
            if (shadow_count >= dwr_pkg::CAPACITY) begin
               res.status = dwr_pkg::ST_FULL;
            end else if (low_end) begin
               shadow_front = (shadow_front == 0) ? dwr_pkg::CAPACITY - 1 : shadow_front - 1;
               shadow_store[shadow_front] = value;
               shadow_count++;
            end else begin
               shadow_store[(shadow_front + shadow_count) % dwr_pkg::CAPACITY] = value;
               shadow_count++;
            end
         end
         dwr_pkg::REQ_REVERSE: begin
            shadow_reversed = !shadow_reversed;
         end
         dwr_pkg::REQ_POP_FRONT, dwr_pkg::REQ_POP_BACK: begin
            low_end = (kind == dwr_pkg::REQ_POP_FRONT) != shadow_reversed;
            if (shadow_count == 0) begin
               res.status = dwr_pkg::ST_EMPTY;
            end else if (low_end) begin
               res.popped = shadow_store[shadow_front];
               res.is_pop = 1'b1;
               shadow_front = (shadow_front + 1) % dwr_pkg::CAPACITY;
               shadow_count--;
            end else begin
               res.popped = shadow_store[(shadow_front + shadow_count - 1) % dwr_pkg::CAPACITY];
               res.is_pop = 1'b1;
               shadow_count--;
            end
         end
         default: begin
         end
      endcase
      res.occupancy = dwr_pkg::COUNT_W'(shadow_count);
      return res;
   endfunction

   task automatic send_request(input logic [2:0] kind,
                               input logic [dwr_pkg::DATA_W-1:0] value);
      deque_outcome_type outcome;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_type = kind;
      req_push_value = value;
      do @(posedge clock); while (req_stall);
      outcome = apply_request(kind, value);
      expected_outcomes = {expected_outcomes, outcome};
   endtask

   task automatic send_random_request(input int push_pct, input int pop_pct);
      int pick;
      logic [2:0] kind;
      logic [dwr_pkg::DATA_W-1:0] value;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0: value = 32'h8000_0000;
         1: value = 32'h7FFF_FFFF;
         default: value = $urandom();
      endcase
      if (pick >= 98) begin
         kind = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
      end else if (pick < push_pct) begin
         kind = $urandom_range(0, 1) ? dwr_pkg::REQ_PUSH_FRONT : dwr_pkg::REQ_PUSH_BACK;
      end else if (pick < push_pct + pop_pct) begin
         kind = $urandom_range(0, 1) ? dwr_pkg::REQ_POP_FRONT : dwr_pkg::REQ_POP_BACK;
      end else begin
         kind = dwr_pkg::REQ_REVERSE;
      end
      send_request(kind, value);
   endtask

   task automatic run_directed_requests();
      // Pops and reversals on an empty deque first.
      send_request(dwr_pkg::REQ_POP_FRONT, 32'h1234_5678);
      send_request(dwr_pkg::REQ_POP_BACK, 32'h0);
      send_request(dwr_pkg::REQ_REVERSE, 32'h0);
      send_request(dwr_pkg::REQ_REVERSE, 32'hFFFF_FFFF);
      // The first push to the front wraps the front slot round to the top.
      send_request(dwr_pkg::REQ_PUSH_FRONT, 32'h7FFF_FFFF);
      send_request(dwr_pkg::REQ_PUSH_BACK, 32'h8000_0000);
      send_request(dwr_pkg::REQ_PUSH_FRONT, 32'h0);
      send_request(dwr_pkg::REQ_PUSH_BACK, 32'hFFFF_FFFF);
      send_request(dwr_pkg::REQ_REVERSE, 32'h0);
      send_request(dwr_pkg::REQ_POP_FRONT, 32'h0);
      send_request(dwr_pkg::REQ_PUSH_FRONT, 32'h5555_5555);
      send_request(dwr_pkg::REQ_PUSH_BACK, 32'hAAAA_AAAA);
      send_request(dwr_pkg::REQ_POP_BACK, 32'h0);
      send_request(dwr_pkg::REQ_REVERSE, 32'h0);
      send_request(dwr_pkg::REQ_POP_BACK, 32'h0);
      send_request(dwr_pkg::REQ_POP_FRONT, 32'h0);
      send_request(REQ_UNUSED_LO, 32'hDEAD_BEEF);
      send_request(REQ_UNUSED_MID, 32'h0000_0001);
      send_request(REQ_UNUSED_HI, 32'hFFFF_FFFF);
      send_request(dwr_pkg::REQ_POP_FRONT, 32'h0);
      send_request(dwr_pkg::REQ_POP_BACK, 32'h0);
      send_request(dwr_pkg::REQ_POP_FRONT, 32'h0);
   endtask

   task automatic run_mixed_traffic();
      repeat (200) send_random_request(40, 40);
   endtask

   task automatic run_fill_to_brim();
      while (shadow_count < dwr_pkg::CAPACITY) send_random_request(90, 4);
      // Hover round the brim so that pushes meet a full deque.
      repeat (40) send_random_request(60, 30);
   endtask

   task automatic run_drain_traffic();
      repeat (300) send_random_request(25, 65);
   endtask

   always @(posedge clock) begin : check_result
      deque_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MISMATCHES) begin
               $display("unexpected result word: status %0d popped %h pop %b occupancy %0d",
                        rsp_status, rsp_popped_value, rsp_is_pop_result, rsp_occupancy);
            end
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_status !== want.status || rsp_popped_value !== want.popped ||
                rsp_is_pop_result !== want.is_pop || rsp_occupancy !== want.occupancy) begin
               mismatch_count++;
               if (mismatch_count <= SHOWN_MISMATCHES) begin
                  $display("mismatch: status %0d/%0d popped %h/%h pop %b/%b occupancy %0d/%0d",
                           want.status, rsp_status, want.popped, rsp_popped_value,
                           want.is_pop, rsp_is_pop_result, want.occupancy, rsp_occupancy);
               end
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed_requests();
      run_mixed_traffic();

      send_idle_pct = 45;
      recv_idle_pct = 12;
      run_fill_to_brim();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_drain_traffic();

      @(negedge clock);
      req_valid = 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[deque_with_reverse.f]
hdl/dwr_pkg.sv
hdl/dwr_ram.sv
hdl/dwr_ctrl.sv
hdl/deque_with_reverse.sv
bench/tb.sv
